/* hdl/mlc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlc_pkg
// Shared types and constants for the masked lane compress block.
// ----------------------------------------------------------------------------
package mlc_pkg;

    // Active lane count (2..8); the port list always carries MAX_LANES lanes.
    localparam int LANES     = 8;
    localparam int MAX_LANES = 8;
    localparam int VALUE_W   = 64;
    localparam int SLOT_W    = $clog2(LANES);
    localparam int COUNT_W   = $clog2(LANES + 1);
    localparam int KEPT_W    = 4;
    localparam int TOTAL_W   = 32;

    // Queue geometry, shared by the middle queue and the result queue.
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef logic [LANES-1:0][VALUE_W-1:0]     lane_vec_t;
    typedef logic [MAX_LANES-1:0][VALUE_W-1:0] out_vec_t;
    typedef logic [LANES-1:0][SLOT_W-1:0]      slot_vec_t;

    // Classified group, handed from the front end to the back end.
    typedef struct packed {
        lane_vec_t          values;
        logic [LANES-1:0]   keep;
        slot_vec_t          slot;
        logic [COUNT_W-1:0] count;
        logic               last;
    } mlc_entry_t;

    // Queue status seen by the consumer side.
    typedef struct packed {
        logic full;
        logic empty;
    } mlc_qstat_t;

endpackage : mlc_pkg
`default_nettype wire

/* hdl/masked_lane_compress.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// masked_lane_compress
// Stream compaction of eight-lane 64-bit groups under a keep mask, with a
// per-group kept count and a saturating running total that clears after a last group.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake          | Fields
//  ---------+--------------------+--------------------------------------------
//  input    | push / full        | lane0_value..lane7_value, select_mask,
//           |                    | last_group
//  result   | pop / empty        | packed0..packed7, kept_count, total_kept
//
//  One group is taken per cycle while full is low. The accepting edge writes
//  the middle queue; the back end then moves the group into the result queue
//  once that queue has room. The result shows on the ports when it reaches
//  the head of the result queue, and can be popped from there.
//  Throughput is set by the back end, which packs and totals one group per
//  cycle from the middle queue while the result queue is not full.
//  Reset clears both queues and the running total; nothing needs sweeping.
//  A stalled result side backs up the result queue, then the middle queue,
//  and only then raises full.
// ----------------------------------------------------------------------------
module masked_lane_compress
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] lane0_value,
    input  wire logic [63:0] lane1_value,
    input  wire logic [63:0] lane2_value,
    input  wire logic [63:0] lane3_value,
    input  wire logic [63:0] lane4_value,
    input  wire logic [63:0] lane5_value,
    input  wire logic [63:0] lane6_value,
    input  wire logic [63:0] lane7_value,
    input  wire logic [7:0]  select_mask,
    input  wire logic        last_group,

    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      packed0,
    output logic [63:0]      packed1,
    output logic [63:0]      packed2,
    output logic [63:0]      packed3,
    output logic [63:0]      packed4,
    output logic [63:0]      packed5,
    output logic [63:0]      packed6,
    output logic [63:0]      packed7,
    output logic [3:0]       kept_count,
    output logic [31:0]      total_kept
);
    import mlc_pkg::*;

    out_vec_t    lanes_all;
    lane_vec_t   lanes_used;
    mlc_entry_t  front_entry;
    mlc_entry_t  mid_entry;
    mlc_qstat_t  mid_stat;
    logic        mid_push;
    logic        mid_pop;
    out_vec_t    packed_vals;

    // Gather the lane ports; lanes at or above LANES are dropped here.
    assign lanes_all[0] = lane0_value;
    assign lanes_all[1] = lane1_value;
    assign lanes_all[2] = lane2_value;
    assign lanes_all[3] = lane3_value;
    assign lanes_all[4] = lane4_value;
    assign lanes_all[5] = lane5_value;
    assign lanes_all[6] = lane6_value;
    assign lanes_all[7] = lane7_value;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lanes_used[i] = lanes_all[i];
        end
    end

    // Front end: classify the group as it arrives.
    mlc_front u_front
    (
        .values_in (lanes_used),
        .keep_in   (select_mask[LANES-1:0]),
        .last_in   (last_group),
        .entry_out (front_entry)
    );

    // Accept whenever the middle queue has room.
    assign full     = mid_stat.full;
    assign mid_push = push && !mid_stat.full;

    mlc_mid_fifo u_mid_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mid_push),
        .wr_data (front_entry),
        .rd_en   (mid_pop),
        .rd_data (mid_entry),
        .stat    (mid_stat)
    );

    // Back end: pack, total, and hold results until popped.
    mlc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .mid_entry  (mid_entry),
        .mid_stat   (mid_stat),
        .mid_pop    (mid_pop),
        .packed_out (packed_vals),
        .count_out  (kept_count),
        .total_out  (total_kept),
        .out_empty  (empty),
        .out_pop    (pop)
    );

    assign packed0 = packed_vals[0];
    assign packed1 = packed_vals[1];
    assign packed2 = packed_vals[2];
    assign packed3 = packed_vals[3];
    assign packed4 = packed_vals[4];
    assign packed5 = packed_vals[5];
    assign packed6 = packed_vals[6];
    assign packed7 = packed_vals[7];

endmodule : masked_lane_compress
`default_nettype wire

/* hdl/mlc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlc_front
// Classify an incoming group: keep bits, destination slot per lane, count.
// ----------------------------------------------------------------------------
module mlc_front
(
    input  wire mlc_pkg::lane_vec_t          values_in,
    input  wire logic [mlc_pkg::LANES-1:0]   keep_in,
    input  wire logic                        last_in,
    output mlc_pkg::mlc_entry_t              entry_out
);
    import mlc_pkg::*;

    logic [COUNT_W-1:0] acc;
    slot_vec_t          slot;

    // Running prefix count: a kept lane lands at the number of kept lanes below it.
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < LANES; i++)
        begin
            slot[i] = acc[SLOT_W-1:0];
            if (keep_in[i])
            begin
                acc = acc + COUNT_W'(1);
            end
        end
    end

    always_comb
    begin
        entry_out.values = values_in;
        entry_out.keep   = keep_in;
        entry_out.slot   = slot;
        entry_out.count  = acc;
        entry_out.last   = last_in;
    end

endmodule : mlc_front
`default_nettype wire

/* hdl/mlc_mid_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlc_mid_fifo
// Short queue of classified groups between the front end and the back end.
// ----------------------------------------------------------------------------
module mlc_mid_fifo
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire mlc_pkg::mlc_entry_t wr_data,
    input  wire logic                rd_en,
    output mlc_pkg::mlc_entry_t      rd_data,
    output mlc_pkg::mlc_qstat_t      stat
);
    import mlc_pkg::*;

    mlc_entry_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);

endmodule : mlc_mid_fifo
`default_nettype wire

/* hdl/mlc_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mlc_back
// Pack kept lanes, update the saturating total, queue the results.
// ----------------------------------------------------------------------------
module mlc_back
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mlc_pkg::mlc_entry_t            mid_entry,
    input  wire mlc_pkg::mlc_qstat_t            mid_stat,
    output logic                                mid_pop,
    output mlc_pkg::out_vec_t                   packed_out,
    output logic [mlc_pkg::KEPT_W-1:0]          count_out,
    output logic [mlc_pkg::TOTAL_W-1:0]         total_out,
    output logic                                out_empty,
    input  wire logic                           out_pop
);
    import mlc_pkg::*;

    typedef struct packed {
        out_vec_t            packed_vals;
        logic [KEPT_W-1:0]   count;
        logic [TOTAL_W-1:0]  total;
    } result_t;

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic [TOTAL_W-1:0] total_sat;
    logic [TOTAL_W:0]   sum;
    out_vec_t           packed_vals;
    result_t            res;

    result_t            q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   q_wr_ptr_reg;
    logic [PTR_W-1:0]   q_rd_ptr_reg;
    logic [CNT_W-1:0]   q_cnt_reg;
    logic [PTR_W-1:0]   q_wr_ptr_next;
    logic [PTR_W-1:0]   q_rd_ptr_next;
    logic [CNT_W-1:0]   q_cnt_next;
    logic               q_full;
    logic               q_push;
    logic               q_pop;

    assign q_full    = (q_cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign out_empty = (q_cnt_reg == '0);
    assign q_push    = !mid_stat.empty && !q_full;
    assign q_pop     = out_pop && !out_empty;
    assign mid_pop   = q_push;

    // Each result slot ORs in the kept lane aimed at it, at most one; unaimed slots stay zero.
    always_comb
    begin
        for (int j = 0; j < MAX_LANES; j++)
        begin
            packed_vals[j] = '0;
            if (j < LANES)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    if (mid_entry.keep[i] && (mid_entry.slot[i] == SLOT_W'(j)))
                    begin
                        packed_vals[j] = packed_vals[j] | mid_entry.values[i];
                    end
                end
            end
        end
    end

    // Saturating running total; clear after reporting a last group.
    always_comb
    begin
        sum        = {1'b0, total_reg} + (TOTAL_W + 1)'(mid_entry.count);
        total_sat  = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        total_next = total_reg;
        if (q_push)
        begin
            total_next = mid_entry.last ? '0 : total_sat;
        end
        res.packed_vals = packed_vals;
        res.count       = KEPT_W'(mid_entry.count);
        res.total       = total_sat;
    end

    always_comb
    begin
        q_wr_ptr_next = q_wr_ptr_reg;
        q_rd_ptr_next = q_rd_ptr_reg;
        q_cnt_next    = q_cnt_reg;
        if (q_push)
        begin
            q_wr_ptr_next = (int'(q_wr_ptr_reg) == QUEUE_DEPTH - 1) ?
                            '0 : q_wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            q_rd_ptr_next = (int'(q_rd_ptr_reg) == QUEUE_DEPTH - 1) ?
                            '0 : q_rd_ptr_reg + PTR_W'(1);
        end
        if (q_push && !q_pop)
        begin
            q_cnt_next = q_cnt_reg + CNT_W'(1);
        end
        else if (q_pop && !q_push)
        begin
            q_cnt_next = q_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            total_reg    <= total_next;
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
            q_cnt_reg    <= q_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[q_wr_ptr_reg] <= res;
        end
    end

    assign packed_out = q_mem[q_rd_ptr_reg].packed_vals;
    assign count_out  = q_mem[q_rd_ptr_reg].count;
    assign total_out  = q_mem[q_rd_ptr_reg].total;

    // Front-end classification must agree with the keep bits.
    a_count_matches_keep : assert property (@(posedge clk) disable iff (!rst_n)
        !mid_stat.empty |-> (int'(mid_entry.count) == $countones(mid_entry.keep)))
        else $error("classified count disagrees with keep bits");

    // Total never drops unless a last group was processed.
    a_total_monotonic : assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !mid_entry.last) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased without a last group");

    // A last group leaves the total cleared.
    a_total_cleared : assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && mid_entry.last) |=> (total_reg == '0))
        else $error("running total not cleared after last group");

    // Result queue never overfills.
    a_queue_bound : assert property (@(posedge clk) disable iff (!rst_n)
        int'(q_cnt_reg) <= QUEUE_DEPTH)
        else $error("result queue count beyond depth");

endmodule : mlc_back
`default_nettype wire
